[sv/rfp_pkg.sv]
// ----------------------------------------------------------------------------
// rfp_pkg: shared definitions of the reader frame parser
// constants, register codes, event codes and the frame record that the
// front end hands to the back end
// ----------------------------------------------------------------------------
`default_nettype none

package rfp_pkg;

    // frame storage
    localparam int MAX_PARAMS   = 32;
    localparam int EPC_BYTES    = 12;
    localparam int EPC_OFFSET   = 3;
    localparam int POLL_MIN_LEN = EPC_OFFSET + EPC_BYTES;
    // only the bytes that a result can ever show are kept
    localparam int KEEP_BYTES   = (MAX_PARAMS < POLL_MIN_LEN) ? MAX_PARAMS : POLL_MIN_LEN;
    localparam int KEEP_IDX_W   = $clog2(KEEP_BYTES);
    localparam int EPC_W        = 8 * EPC_BYTES;
    localparam int EPC_HIGH_W   = 32;
    localparam int EPC_LOW_W    = EPC_W - EPC_HIGH_W;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int EVENT_W   = 3;
    localparam int PC_W      = 16;
    localparam int CFG_IDX_W = 3;

    // queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER     = 3'd0,
        CFG_END        = 3'd1,
        CFG_POLL       = 3'd2,
        CFG_MULTI_POLL = 3'd3,
        CFG_FAILURE    = 3'd4,
        CFG_INV_CODE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] poll_command;
        logic [BYTE_W-1:0] multi_poll_command;
        logic [BYTE_W-1:0] failure_command;
        logic [BYTE_W-1:0] inventory_fail_code;
    } t_cfg;

    typedef enum logic [EVENT_W-1:0] {
        EV_NEW_TAG     = 3'd0,
        EV_SAME_TAG    = 3'd1,
        EV_TAG_REMOVED = 3'd2,
        EV_NO_TAG      = 3'd3,
        EV_FAILURE     = 3'd4,
        EV_BAD_FRAME   = 3'd5,
        EV_OTHER_FRAME = 3'd6
    } t_event;

    // frame class decided by the front end
    typedef enum logic [2:0] {
        FK_BAD,
        FK_POLL,
        FK_INV_FAIL,
        FK_FAIL,
        FK_OTHER
    } t_kind;

    typedef struct packed {
        t_kind                            kind;
        logic [BYTE_W-1:0]                command;
        logic                             has_param;
        logic [KEEP_BYTES-1:0][BYTE_W-1:0] params;
    } t_frame;

endpackage

`default_nettype wire

[sv/rfp_if.sv]
// ----------------------------------------------------------------------------
// rfp_if: channel interfaces of the reader frame parser
// received byte channel, result channel and register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface rfp_byte_if import rfp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfp_res_if import rfp_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [EVENT_W-1:0]    event_res;
    logic [BYTE_W-1:0]     command;
    logic [BYTE_W-1:0]     error_code;
    logic [BYTE_W-1:0]     rssi;
    logic [PC_W-1:0]       protocol_control;
    logic [EPC_HIGH_W-1:0] epc_high;
    logic [EPC_LOW_W-1:0]  epc_low;

    modport source (output valid, output event_res, output command, output error_code,
                    output rssi, output protocol_control, output epc_high,
                    output epc_low, input ready);
    modport sink   (input valid, input event_res, input command, input error_code,
                    input rssi, input protocol_control, input epc_high,
                    input epc_low, output ready);
endinterface

interface rfp_cfg_if import rfp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/rfp_front.sv]
// ----------------------------------------------------------------------------
// rfp_front: byte parser and frame classifier
// walks the frame layout one byte per cycle while the record queue is not
// full, keeps the running checksum and the leading parameter bytes, and
// queues one record per finished frame
`default_nettype none

module rfp_front import rfp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rfp_byte_if.sink    i_rx,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_full,
    output t_frame      o_frame,
    output logic        o_push
);

    typedef enum logic [2:0] {
        S_HEADER, S_TYPE, S_CMD, S_LENHI, S_LENLO, S_PARAM, S_SUM, S_END
    } t_state;

    t_state                          r_state;
    logic [LEN_W-1:0]                r_len;
    logic [LEN_W-1:0]                r_idx;
    logic [BYTE_W-1:0]               r_sum;
    logic [BYTE_W-1:0]               r_cmd;
    logic                            r_sum_ok;
    logic [KEEP_BYTES-1:0][BYTE_W-1:0] r_params;

    logic              accept;
    logic [BYTE_W-1:0] rx;
    logic [BYTE_W-1:0] n_sum;
    logic [LEN_W-1:0]  n_idx;
    logic [LEN_W-1:0]  n_len;
    logic              has_param;
    logic              poll_len;
    logic              end_ok;
    logic              is_poll;
    t_kind             kind;

    assign i_rx.ready = !i_full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign rx         = i_rx.rx_byte;
    assign n_sum      = r_sum + rx;
    assign n_idx      = r_idx + LEN_W'(1);
    assign n_len      = {r_len[LEN_W-1:BYTE_W], rx};

    assign has_param = (r_idx != '0);
    assign poll_len  = (r_idx >= LEN_W'(POLL_MIN_LEN));
    assign end_ok    = (rx == i_cfg.end_byte) && r_sum_ok;
    assign is_poll   = (r_cmd == i_cfg.poll_command) || (r_cmd == i_cfg.multi_poll_command);

    always_comb begin
        priority if (!end_ok) begin
            kind = FK_BAD;
        end else if (is_poll && poll_len) begin
            kind = FK_POLL;
        end else if ((r_cmd == i_cfg.failure_command) && has_param) begin
            kind = (r_params[0] == i_cfg.inventory_fail_code) ? FK_INV_FAIL : FK_FAIL;
        end else begin
            kind = FK_OTHER;
        end
    end

    assign o_push            = accept && (r_state == S_END);
    assign o_frame.kind      = kind;
    assign o_frame.command   = r_cmd;
    assign o_frame.has_param = has_param;
    assign o_frame.params    = r_params;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_HEADER;
            r_len    <= '0;
            r_idx    <= '0;
            r_sum    <= '0;
            r_cmd    <= '0;
            r_sum_ok <= 1'b0;
        end else if (accept) begin
            unique case (r_state)
                S_HEADER: begin
                    if (rx == i_cfg.header_byte) begin
                        r_sum    <= '0;
                        r_idx    <= '0;
                        r_len    <= '0;
                        r_sum_ok <= 1'b0;
                        r_state  <= S_TYPE;
                    end
                end
                S_TYPE: begin
                    r_sum   <= n_sum;
                    r_state <= S_CMD;
                end
                S_CMD: begin
                    r_sum   <= n_sum;
                    r_cmd   <= rx;
                    r_state <= S_LENHI;
                end
                S_LENHI: begin
                    r_sum   <= n_sum;
                    r_len   <= {rx, BYTE_W'(0)};
                    r_state <= S_LENLO;
                end
                S_LENLO: begin
                    r_sum   <= n_sum;
                    r_len   <= n_len;
                    r_state <= (n_len == '0) ? S_SUM : S_PARAM;
                end
                S_PARAM: begin
                    r_sum <= n_sum;
                    r_idx <= n_idx;
                    if (n_idx >= r_len) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sum_ok <= (rx == r_sum);
                    r_state  <= S_END;
                end
                S_END: begin
                    r_state <= S_HEADER;
                end
                default: begin
                    r_state <= S_HEADER;
                end
            endcase
        end
    end

    // leading parameter bytes, later ones only feed the checksum
    always_ff @(posedge i_clk) begin
        if (accept && (r_state == S_PARAM) && (r_idx < LEN_W'(KEEP_BYTES))) begin
            r_params[r_idx[KEEP_IDX_W-1:0]] <= rx;
        end
    end

`ifndef SYNTHESIS
    a_param_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PARAM) |-> ((r_len != '0) && (r_idx < r_len)))
        else $error("parameter phase entered with no bytes left");
`endif

endmodule

`default_nettype wire

[sv/rfp_queue.sv]
// ----------------------------------------------------------------------------
// rfp_queue: short frame record queue
// decouples the byte parser from the result stage
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_queue import rfp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_frame i_frame,
    input  wire logic   i_pop,
    output t_frame      o_frame,
    output logic        o_full,
    output logic        o_empty
);

    t_frame             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_frame = r_mem[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");
    a_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("frame record pushed into a full queue");
`endif

endmodule

`default_nettype wire

[sv/rfp_back.sv]
// ----------------------------------------------------------------------------
// rfp_back: result stage
// compares poll EPCs with the stored tag, keeps the tag, and holds the
// result request in an output register
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_back import rfp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_frame i_frame,
    input  wire logic   i_empty,
    output logic        o_pop,
    rfp_res_if.source   o_res
);

    logic [EPC_W-1:0]      r_tag;
    logic                  r_valid;
    t_event                r_event;
    logic [BYTE_W-1:0]     r_command;
    logic [BYTE_W-1:0]     r_error;
    logic [BYTE_W-1:0]     r_rssi;
    logic [PC_W-1:0]       r_pc;
    logic [EPC_W-1:0]      r_epc;

    logic [EPC_W-1:0]  epc;
    logic              tag_match;
    t_event            n_event;
    logic [BYTE_W-1:0] n_error;
    logic              is_poll;

    always_comb begin
        for (int i = 0; i < EPC_BYTES; i++) begin
            epc[EPC_W-1-8*i -: 8] = i_frame.params[EPC_OFFSET+i];
        end
    end

    assign tag_match = (epc == r_tag);
    assign is_poll   = (i_frame.kind == FK_POLL);
    assign o_pop     = !i_empty && (!r_valid || o_res.ready);

    always_comb begin
        n_error = (i_frame.has_param && (i_frame.kind != FK_BAD)) ? i_frame.params[0] : '0;
        unique case (i_frame.kind)
            FK_BAD:      n_event = EV_BAD_FRAME;
            FK_POLL:     n_event = tag_match ? EV_SAME_TAG : EV_NEW_TAG;
            FK_INV_FAIL: n_event = (r_tag != '0) ? EV_TAG_REMOVED : EV_NO_TAG;
            FK_FAIL:     n_event = EV_FAILURE;
            default:     n_event = EV_OTHER_FRAME;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tag   <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop && is_poll) begin
                r_tag <= epc;
            end else if (o_pop && (i_frame.kind == FK_INV_FAIL)) begin
                r_tag <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_event   <= n_event;
            r_command <= i_frame.command;
            r_error   <= n_error;
            r_rssi    <= is_poll ? i_frame.params[0] : '0;
            r_pc      <= is_poll ? {i_frame.params[1], i_frame.params[2]} : '0;
            r_epc     <= is_poll ? epc : '0;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.event_res        = r_event;
    assign o_res.command          = r_command;
    assign o_res.error_code       = r_error;
    assign o_res.rssi             = r_rssi;
    assign o_res.protocol_control = r_pc;
    assign o_res.epc_high         = r_epc[EPC_W-1 -: EPC_HIGH_W];
    assign o_res.epc_low          = r_epc[EPC_LOW_W-1:0];

`ifndef SYNTHESIS
    a_inv_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_frame.kind == FK_INV_FAIL)) |=> (r_tag == '0))
        else $error("inventory failure did not clear the stored tag");
    a_poll_stores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_poll) |=> ((r_tag == $past(epc)) && (r_epc == r_tag)))
        else $error("poll response did not store its tag");
`endif

endmodule

`default_nettype wire

[sv/rfid_reader_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// rfid_reader_frame_parser_unit: serial frame parser of a UHF tag reader
// turns the reader's byte stream into tag events and failure reports
// ----------------------------------------------------------------------------
// The unit takes one received byte per request on i_rx and can accept a byte
// every clock cycle while the record queue is not full. It looks for frames
// of the form header, type, command, 16-bit big-endian length, parameters,
// checksum, end byte; the checksum is the low byte of the sum from type
// through the last parameter. Each frame gives exactly one result request on
// o_res once its record has passed the record queue and the output register,
// and later while an earlier result is still waiting in the output register;
// every other byte gives none. Bytes outside a frame that are not the header
// byte are dropped. A frame with a wrong checksum or end byte is a bad frame
// carrying only its command. A poll response (single or multiple) with at
// least fifteen parameter bytes reports RSSI, PC word and the 96-bit EPC and
// marks it as a new tag or the same tag; the EPC is stored in both cases. A
// failure response with the inventory failure code clears the stored tag and
// reports tag removed, or no tag if none was stored; other failure codes are
// passed on. The byte parser and the result stage are split by a two-entry
// record queue, so a stalled result consumer only holds off i_rx once three
// finished frames are waiting (one in the output register, two in the queue);
// while the queue is full every byte on i_rx is held off, not only end bytes.
// Registers on i_cfg (header byte, end byte, poll and multiple poll command,
// failure command, inventory failure code, indexes 0 to 5) are written at any
// time and take effect once the write is registered; other indexes are
// ignored. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rfid_reader_frame_parser_unit import rfp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rfp_byte_if.sink   i_rx,
    rfp_cfg_if.sink    i_cfg,
    rfp_res_if.source  o_res
);

    // configuration registers
    t_cfg   r_cfg;

    // record queue connections
    t_frame push_frame;
    t_frame head_frame;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte         <= 8'hAA;
            r_cfg.end_byte            <= 8'hDD;
            r_cfg.poll_command        <= 8'h22;
            r_cfg.multi_poll_command  <= 8'h27;
            r_cfg.failure_command     <= 8'hFF;
            r_cfg.inventory_fail_code <= 8'h15;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_HEADER:     r_cfg.header_byte         <= i_cfg.data;
                CFG_END:        r_cfg.end_byte            <= i_cfg.data;
                CFG_POLL:       r_cfg.poll_command        <= i_cfg.data;
                CFG_MULTI_POLL: r_cfg.multi_poll_command  <= i_cfg.data;
                CFG_FAILURE:    r_cfg.failure_command     <= i_cfg.data;
                CFG_INV_CODE:   r_cfg.inventory_fail_code <= i_cfg.data;
                default: begin
                    // unknown index, nothing to write
                end
            endcase
        end
    end

    // front end: frame parsing and classification
    rfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_frame (push_frame),
        .o_push  (push)
    );

    // finished frames waiting for the result stage
    rfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_frame (head_frame),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back end: tag tracking and result register
    rfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (head_frame),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
